// ===== hdl/rvcg_pkg.sv =====
`default_nettype none

package rvcg_pkg;

    // Raster geometry.
    localparam logic [8:0] LINE_COLUMNS    = 9'd448;
    localparam logic [8:0] FRAME_LINES_PAL = 9'd312;
    localparam logic [8:0] FRAME_LINES_NTSC = 9'd264;
    localparam logic [8:0] DISPLAY_LINES   = 9'd192;
    localparam logic [8:0] DISPLAY_COLUMNS = 9'd256;
    localparam logic [8:0] FETCH_FIRST_COL = 9'd8;
    localparam logic [8:0] FETCH_END_COL   = 9'd264;
    localparam logic [8:0] HBLANK_FIRST    = 9'd320;
    localparam logic [8:0] HBLANK_LAST     = 9'd415;
    localparam logic [8:0] BURST_FIRST     = 9'd384;
    localparam logic [8:0] BURST_LAST      = 9'd399;
    localparam logic [8:0] HSYNC_FIRST_EARLY = 9'd336;
    localparam logic [8:0] HSYNC_LAST_EARLY  = 9'd367;
    localparam logic [8:0] HSYNC_FIRST_LATE  = 9'd344;
    localparam logic [8:0] HSYNC_LAST_LATE   = 9'd375;
    localparam logic [8:0] VSYNC_FIRST_PAL   = 9'd248;
    localparam logic [8:0] VSYNC_LAST_PAL    = 9'd251;
    localparam logic [8:0] VSYNC_FIRST_NTSC  = 9'd216;
    localparam logic [8:0] VSYNC_LAST_NTSC   = 9'd219;
    localparam logic [8:0] INTERRUPT_LINE    = 9'd248;

    // Chip type codes.
    localparam logic [2:0] CHIP_5C102E  = 3'd0;
    localparam logic [2:0] CHIP_5C112E  = 3'd1;
    localparam logic [2:0] CHIP_6C001E6 = 3'd2;
    localparam logic [2:0] CHIP_6C001E7 = 3'd3;
    localparam logic [2:0] CHIP_6C011E  = 3'd4;

    // Operation codes.
    localparam logic OP_TICK         = 1'b0;
    localparam logic OP_BORDER_WRITE = 1'b1;

    // Fetch slot codes, taken from (column + 1) masked with 4'hb.
    localparam logic [3:0] SLOT_BITMAP_COL = 4'h8;
    localparam logic [3:0] SLOT_ROW        = 4'h9;
    localparam logic [3:0] SLOT_ATTR_COL   = 4'hb;
    localparam logic [6:0] ATTR_ROW_BASE   = 7'h30;

    typedef struct packed {
        logic       operation;
        logic [7:0] data_byte;
        logic       addr_bit14;
        logic       addr_bit15;
        logic       mem_request_n;
        logic       io_request_n;
    } t_in_item;

    typedef struct packed {
        logic [4:0] pixel_code;
        logic       hsync;
        logic       vsync;
        logic       hblank;
        logic       colour_burst;
        logic       odd_line;
        logic [6:0] video_address;
        logic       address_valid;
        logic       video_ras;
        logic       video_cas;
        logic       frame_interrupt;
        logic       cpu_clock;
    } t_out_item;

endpackage

`default_nettype wire

// ===== hdl/raster_video_and_cpu_clock_gen_unit.sv =====
// Raster video generator and CPU clock gate, one pixel-clock tick per item.
// Throughput: one item per cycle while the skid stage is empty; the whole tick
// is one pass of logic from the raster state and the accepted item into the
// output register. Reset (synchronous, active low) clears all counters and
// latches, selects chip type 6C001E7 and empties the output register and its
// skid stage.
`default_nettype none

module raster_video_and_cpu_clock_gen_unit (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    // Input item channel.
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire rvcg_pkg::t_in_item  i_in_item,
    // Result item channel.
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output rvcg_pkg::t_out_item      o_out_item,
    // Chip type register write port.
    input  wire                      i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire  [2:0]               i_cfg_data
);

    // Configuration and raster state.
    logic [2:0] r_chip_type;
    logic [8:0] r_column,  n_column;
    logic [8:0] r_line,    n_line;
    logic [4:0] r_flash,   n_flash;
    logic [7:0] r_bitmap,  n_bitmap;
    logic [7:0] r_attr,    n_attr;
    logic [2:0] r_ink,     n_ink;
    logic [2:0] r_paper,   n_paper;
    logic [1:0] r_fb,      n_fb;
    logic [7:0] r_shifter, n_shifter;
    logic [2:0] r_border;
    logic       r_parity,  n_parity;
    logic       r_ras,     n_ras;
    logic       r_cas,     n_cas;
    logic       r_cpu_clk, n_cpu_clk;
    logic       r_mem_seen, n_mem_seen;
    logic       r_io_seen,  n_io_seen;

    // Output register and skid stage.
    logic                 r_out_valid;
    logic                 r_skid_valid;
    rvcg_pkg::t_out_item  r_out;
    rvcg_pkg::t_out_item  r_skid;
    rvcg_pkg::t_out_item  n_result;

    logic accept;
    logic tick;
    logic pop;

    // The upstream side only stalls while the skid stage holds an item, so
    // the downstream stall never reaches it combinationally.
    assign o_in_stall  = r_skid_valid;
    assign accept      = i_in_valid && !r_skid_valid;
    assign tick        = accept && (i_in_item.operation == rvcg_pkg::OP_TICK);
    assign pop         = r_out_valid && !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;
    assign o_cfg_ready = 1'b1;

    // Per-tick combinational work.
    logic [8:0] col_inc, line_inc, frame_lines, hs_first, hs_last, vs_first, vs_last;
    logic [8:0] c, v;
    logic       in_border, hblank, hsync, vsync, burst, intr;
    logic       ae, valid_addr, cas_out, gate_zone, page_c, memc, ioc;
    logic [3:0] col_lo_inc, slot;
    logic [6:0] vaddr;
    logic [7:0] shift_loaded;
    logic [2:0] colour;
    logic       late_sync, ntsc;

    always_comb begin
        ntsc        = (r_chip_type == rvcg_pkg::CHIP_6C011E);
        late_sync   = !((r_chip_type == rvcg_pkg::CHIP_5C102E) ||
                        (r_chip_type == rvcg_pkg::CHIP_5C112E));
        frame_lines = ntsc ? rvcg_pkg::FRAME_LINES_NTSC : rvcg_pkg::FRAME_LINES_PAL;
        hs_first    = late_sync ? rvcg_pkg::HSYNC_FIRST_LATE : rvcg_pkg::HSYNC_FIRST_EARLY;
        hs_last     = late_sync ? rvcg_pkg::HSYNC_LAST_LATE  : rvcg_pkg::HSYNC_LAST_EARLY;
        vs_first    = ntsc ? rvcg_pkg::VSYNC_FIRST_NTSC : rvcg_pkg::VSYNC_FIRST_PAL;
        vs_last     = ntsc ? rvcg_pkg::VSYNC_LAST_NTSC  : rvcg_pkg::VSYNC_LAST_PAL;

        // Column, line and flash counters. A line count past the frame end
        // (after a chip type change) wraps on the next increment.
        col_inc  = r_column + 9'd1;
        line_inc = r_line + 9'd1;
        n_column = col_inc;
        n_line   = r_line;
        n_flash  = r_flash;
        if (col_inc >= rvcg_pkg::LINE_COLUMNS) begin
            n_column = '0;
            n_line   = line_inc;
            if (line_inc >= frame_lines) begin
                n_line  = '0;
                n_flash = r_flash + 5'd1;
            end
        end
        c = n_column;
        v = n_line;

        // Attribute output latch and shifter load, or border paper, every eight columns.
        n_ink     = r_ink;
        n_paper   = r_paper;
        n_fb      = r_fb;
        n_shifter = r_shifter;
        if (c[2:0] == 3'd5) begin
            if (c >= rvcg_pkg::FETCH_FIRST_COL && c < rvcg_pkg::FETCH_END_COL &&
                v < rvcg_pkg::DISPLAY_LINES) begin
                n_ink     = r_attr[2:0];
                n_paper   = r_attr[5:3];
                n_fb      = r_attr[7:6];
                n_shifter = (r_attr[7] && r_flash[4]) ? ~r_bitmap : r_bitmap;
            end else begin
                n_paper = r_border;
                n_fb    = 2'b00;
            end
        end
        shift_loaded = n_shifter;

        hblank    = (c >= rvcg_pkg::HBLANK_FIRST) && (c <= rvcg_pkg::HBLANK_LAST);
        hsync     = (c >= hs_first) && (c <= hs_last);
        burst     = (c >= rvcg_pkg::BURST_FIRST) && (c <= rvcg_pkg::BURST_LAST);
        vsync     = (v >= vs_first) && (v <= vs_last);
        in_border = (c >= rvcg_pkg::DISPLAY_COLUMNS) || (v >= rvcg_pkg::DISPLAY_LINES);
        n_parity  = (c == hs_first) ? v[0] : r_parity;

        if (hblank || vsync) begin
            colour = 3'd0;
        end else begin
            colour = shift_loaded[7] ? n_ink : n_paper;
        end
        n_shifter = {shift_loaded[6:0], 1'b0};

        // Video memory fetch: row and column addresses and data latches.
        ae         = !in_border && (c[3:0] >= 4'd7);
        col_lo_inc = c[3:0] + 4'd1;
        slot       = col_lo_inc & 4'hb;
        vaddr      = '0;
        valid_addr = 1'b0;
        n_ras      = r_ras;
        n_bitmap   = r_bitmap;
        n_attr     = r_attr;
        cas_out    = r_cas;
        if (ae) begin
            case (slot)
                rvcg_pkg::SLOT_BITMAP_COL: begin
                    vaddr      = {v[4:3], c[7:3]};
                    valid_addr = 1'b1;
                end
                rvcg_pkg::SLOT_ROW: begin
                    vaddr      = {1'b0, v[7:6], v[2:0], v[5]};
                    valid_addr = 1'b1;
                end
                rvcg_pkg::SLOT_ATTR_COL: begin
                    vaddr      = rvcg_pkg::ATTR_ROW_BASE | {4'd0, v[7:5]};
                    valid_addr = 1'b1;
                end
                default: begin
                    vaddr      = '0;
                    valid_addr = 1'b0;
                end
            endcase
            cas_out = c[3];
            if (c[3]) begin
                n_ras = (c[1:0] != 2'b11);
                if (c[0]) begin
                    if (c[1]) begin
                        n_attr = i_in_item.data_byte;
                    end else begin
                        n_bitmap = i_in_item.data_byte;
                    end
                end
            end
        end

        // CPU clock gating under memory and I/O contention.
        gate_zone = !in_border && (c[3:2] != 2'b00);
        page_c    = i_in_item.addr_bit14 && !i_in_item.addr_bit15;
        memc      = 1'b0;
        ioc       = 1'b0;
        if (gate_zone) begin
            case (r_chip_type)
                rvcg_pkg::CHIP_5C102E: begin
                    memc = page_c && !r_mem_seen && !r_io_seen && r_cpu_clk;
                    ioc  = !r_cpu_clk && !r_io_seen && (c[3:1] != 3'b100) &&
                           !i_in_item.io_request_n;
                end
                rvcg_pkg::CHIP_5C112E: begin
                    memc = (!i_in_item.io_request_n || page_c) && !r_mem_seen &&
                           !r_io_seen && r_cpu_clk;
                    ioc  = !r_cpu_clk && !r_io_seen && (c[3:1] != 3'b100) &&
                           !i_in_item.io_request_n;
                end
                default: begin
                    memc = (!i_in_item.io_request_n || page_c) && !r_mem_seen &&
                           !r_io_seen && r_cpu_clk;
                    ioc  = !r_cpu_clk && !r_io_seen && !i_in_item.io_request_n;
                end
            endcase
        end
        n_cpu_clk  = r_cpu_clk;
        n_mem_seen = r_mem_seen;
        n_io_seen  = r_io_seen;
        if (!memc && !ioc) begin
            n_cpu_clk = c[0];
            if (c[0]) begin
                n_mem_seen = !i_in_item.mem_request_n;
                n_io_seen  = !i_in_item.io_request_n;
            end
        end

        intr = (v == rvcg_pkg::INTERRUPT_LINE) && (c[8:6] == 3'b000);

        // Column strobe as seen on the rising half of the pixel clock.
        n_cas = !in_border && c[3] && !c[0];

        n_result.pixel_code      = {n_fb, colour};
        n_result.hsync           = hsync;
        n_result.vsync           = vsync;
        n_result.hblank          = hblank;
        n_result.colour_burst    = burst;
        n_result.odd_line        = n_parity;
        n_result.video_address   = vaddr;
        n_result.address_valid   = valid_addr;
        n_result.video_ras       = n_ras;
        n_result.video_cas       = cas_out;
        n_result.frame_interrupt = intr;
        n_result.cpu_clock       = n_cpu_clk;
    end

    // Raster state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chip_type <= rvcg_pkg::CHIP_6C001E7;
            r_column    <= '0;
            r_line      <= '0;
            r_flash     <= '0;
            r_bitmap    <= '0;
            r_attr      <= '0;
            r_ink       <= '0;
            r_paper     <= '0;
            r_fb        <= '0;
            r_shifter   <= '0;
            r_border    <= '0;
            r_parity    <= 1'b0;
            r_ras       <= 1'b0;
            r_cas       <= 1'b0;
            r_cpu_clk   <= 1'b0;
            r_mem_seen  <= 1'b0;
            r_io_seen   <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_chip_type <= i_cfg_data;
            end
            if (accept && (i_in_item.operation == rvcg_pkg::OP_BORDER_WRITE)) begin
                r_border <= i_in_item.data_byte[2:0];
            end
            if (tick) begin
                r_column   <= n_column;
                r_line     <= n_line;
                r_flash    <= n_flash;
                r_bitmap   <= n_bitmap;
                r_attr     <= n_attr;
                r_ink      <= n_ink;
                r_paper    <= n_paper;
                r_fb       <= n_fb;
                r_shifter  <= n_shifter;
                r_parity   <= n_parity;
                r_ras      <= n_ras;
                r_cas      <= n_cas;
                r_cpu_clk  <= n_cpu_clk;
                r_mem_seen <= n_mem_seen;
                r_io_seen  <= n_io_seen;
            end
        end
    end

    // Output register with a skid stage behind it. A new result goes to the
    // skid stage only when the output register is full and stalled.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (pop) begin
                r_out        <= r_skid;
                r_skid_valid <= 1'b0;
            end
        end else if (tick) begin
            if (r_out_valid && !pop) begin
                r_skid       <= n_result;
                r_skid_valid <= 1'b1;
            end else begin
                r_out       <= n_result;
                r_out_valid <= 1'b1;
            end
        end else if (pop) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== verif/raster_video_and_cpu_clock_gen_unit_test.sv =====
`timescale 1ns / 100ps

module raster_video_and_cpu_clock_gen_unit_test;

    // The limit leaves room for every idle gap and stall many times over.
    localparam int unsigned CYCLE_LIMIT   = 60_000;
    // Cycles allowed after the last expected result for the block to go quiet.
    localparam int unsigned SETTLE_CYCLES = 4;
    // Only the first errors are printed. Every one of them is counted.
    localparam int unsigned MAX_SHOWN     = 40;
    localparam int unsigned TICKS_PER_MIX = 110;
    localparam int unsigned NO_IDLE_TICKS = 150;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    rvcg_pkg::t_in_item   i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    rvcg_pkg::t_out_item  o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [2:0]           i_cfg_data  = rvcg_pkg::CHIP_6C001E7;

    // When this is low, neither side inserts gaps or stalls.
    bit          idle_on = 1'b1;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned ticks_seen = 0;
    int unsigned border_writes = 0;

    // The raster state as the block should hold it. It is updated at the clock
    // edge that accepts each item.
    logic [2:0] chip_sel;
    logic [8:0] col_cnt;
    logic [8:0] line_cnt;
    logic [4:0] flash_cnt;
    logic [7:0] bitmap_byte;
    logic [7:0] attr_byte;
    logic [7:0] shifter;
    logic [2:0] ink;
    logic [2:0] paper;
    logic [2:0] border_rgb;
    logic [1:0] flash_bright_bits;
    logic       border_area;
    logic       parity_bit;
    logic       ras_st;
    logic       cas_st;
    logic       cpu_clk_st;
    logic       mreq_seen;
    logic       iorq_seen;

    // Video outputs still owed by the block, oldest first.
    rvcg_pkg::t_out_item  due_pixels[$];

    raster_video_and_cpu_clock_gen_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Advances the raster by one pixel-clock tick and returns what the block
    // should present for it.
    function automatic rvcg_pkg::t_out_item advance_raster(input rvcg_pkg::t_in_item it);
        rvcg_pkg::t_out_item  res;
        logic [8:0] c;
        logic [8:0] v;
        logic [8:0] hs_lo;
        logic [8:0] hs_hi;
        logic [8:0] vs_lo;
        logic [8:0] vs_hi;
        logic [4:0] code;
        logic [3:0] slot;
        logic       page_hit;
        logic       req_idle;
        logic       mem_hold;
        logic       io_hold;

        res = '0;
        mem_hold = 1'b0;
        io_hold = 1'b0;
        // The two older chips start horizontal sync eight columns earlier. Only
        // the NTSC chip moves vertical sync; codes 5 to 7 time as PAL.
        hs_lo = (chip_sel <= rvcg_pkg::CHIP_5C112E) ? rvcg_pkg::HSYNC_FIRST_EARLY
                                                     : rvcg_pkg::HSYNC_FIRST_LATE;
        hs_hi = (chip_sel <= rvcg_pkg::CHIP_5C112E) ? rvcg_pkg::HSYNC_LAST_EARLY
                                                     : rvcg_pkg::HSYNC_LAST_LATE;
        vs_lo = (chip_sel == rvcg_pkg::CHIP_6C011E) ? rvcg_pkg::VSYNC_FIRST_NTSC
                                                     : rvcg_pkg::VSYNC_FIRST_PAL;
        vs_hi = (chip_sel == rvcg_pkg::CHIP_6C011E) ? rvcg_pkg::VSYNC_LAST_NTSC
                                                     : rvcg_pkg::VSYNC_LAST_PAL;

        // A line count already past the frame length, left by a switch to the
        // shorter NTSC frame, wraps at the next line.
        col_cnt = col_cnt + 9'd1;
        if (col_cnt >= rvcg_pkg::LINE_COLUMNS) begin
            col_cnt = '0;
            line_cnt = line_cnt + 9'd1;
            if (line_cnt >= ((chip_sel == rvcg_pkg::CHIP_6C011E) ?
                             rvcg_pkg::FRAME_LINES_NTSC : rvcg_pkg::FRAME_LINES_PAL)) begin
                line_cnt = '0;
                flash_cnt = flash_cnt + 5'd1;
            end
        end
        c = col_cnt;
        v = line_cnt;

        // Once per character cell the output latches take the fetched bytes,
        // or the border colour outside the fetch area.
        if (c[2:0] == 3'd5) begin
            if (c >= rvcg_pkg::FETCH_FIRST_COL && c < rvcg_pkg::FETCH_END_COL &&
                v < rvcg_pkg::DISPLAY_LINES) begin
                ink = attr_byte[2:0];
                paper = attr_byte[5:3];
                flash_bright_bits = attr_byte[7:6];
                shifter = bitmap_byte;
                if (flash_bright_bits[1] && flash_cnt[4]) begin
                    shifter = ~shifter;
                end
            end else begin
                paper = border_rgb;
                flash_bright_bits = 2'b00;
            end
        end

        res.hblank = c >= rvcg_pkg::HBLANK_FIRST && c <= rvcg_pkg::HBLANK_LAST;
        res.hsync = c >= hs_lo && c <= hs_hi;
        if (c == hs_lo) begin
            parity_bit = v[0];
        end
        res.colour_burst = c >= rvcg_pkg::BURST_FIRST && c <= rvcg_pkg::BURST_LAST;
        res.vsync = v >= vs_lo && v <= vs_hi;
        border_area = c >= rvcg_pkg::DISPLAY_COLUMNS || v >= rvcg_pkg::DISPLAY_LINES;
        if (res.hblank || res.vsync) begin
            code = '0;
        end else begin
            code = {2'b00, shifter[7] ? ink : paper};
        end
        code[4:3] = flash_bright_bits;
        res.pixel_code = code;
        shifter = shifter << 1;

        // Video memory fetch: bitmap column, row address, then attribute column.
        if (!border_area && c[3:0] >= 4'd7) begin
            slot = (c[3:0] + 4'd1) & 4'hb;
            case (slot)
                rvcg_pkg::SLOT_BITMAP_COL: begin
                    res.video_address = {v[4:3], c[7:3]};
                    res.address_valid = 1'b1;
                end
                rvcg_pkg::SLOT_ROW: begin
                    res.video_address = {1'b0, v[7:6], v[2:0], v[5]};
                    res.address_valid = 1'b1;
                end
                rvcg_pkg::SLOT_ATTR_COL: begin
                    res.video_address = rvcg_pkg::ATTR_ROW_BASE | {4'b0000, v[7:5]};
                    res.address_valid = 1'b1;
                end
                default: begin
                end
            endcase
            cas_st = c[3];
            if (c[3]) begin
                ras_st = c[1:0] != 2'b11;
                if (c[0]) begin
                    if (c[1]) begin
                        attr_byte = it.data_byte;
                    end else begin
                        bitmap_byte = it.data_byte;
                    end
                end
            end
        end
        res.video_cas = cas_st;

        // CPU clock gating. The older chips let I/O run in the first two
        // columns of the fetch group.
        if (!border_area && c[3:2] != 2'b00) begin
            page_hit = it.addr_bit14 && !it.addr_bit15;
            req_idle = !mreq_seen && !iorq_seen && cpu_clk_st;
            if (chip_sel == rvcg_pkg::CHIP_5C102E) begin
                mem_hold = page_hit && req_idle;
            end else begin
                mem_hold = (!it.io_request_n || page_hit) && req_idle;
            end
            io_hold = !cpu_clk_st && !iorq_seen && !it.io_request_n;
            if (chip_sel <= rvcg_pkg::CHIP_5C112E && c[3:1] == 3'b100) begin
                io_hold = 1'b0;
            end
        end
        if (!mem_hold && !io_hold) begin
            cpu_clk_st = c[0];
            if (cpu_clk_st) begin
                mreq_seen = !it.mem_request_n;
                iorq_seen = !it.io_request_n;
            end
        end

        res.frame_interrupt = v == rvcg_pkg::INTERRUPT_LINE && c[8:6] == 3'b000;
        // The column strobe seen between fetches comes from the rising half
        // of the pixel clock.
        cas_st = !border_area && c[3] && !c[0];
        res.odd_line = parity_bit;
        res.video_ras = ras_st;
        res.cpu_clock = cpu_clk_st;
        return res;
    endfunction

    task automatic log_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_SHOWN) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            log_mismatch($sformatf("%s is %0d, expected %0d (tick %0d)", name, got,
                                   want, ticks_seen));
        end
    endtask

    // Both channels are sampled at the rising edge, before any of this
    // edge's nonblocking updates land, so the order of processes does not
    // matter. Prediction runs before checking so that the queue is always
    // oldest first.
    always @(posedge i_clk) begin : scoreboard
        rvcg_pkg::t_out_item want;

        if (!i_rst_n) begin
            chip_sel = rvcg_pkg::CHIP_6C001E7;
            col_cnt = '0;
            line_cnt = '0;
            flash_cnt = '0;
            bitmap_byte = '0;
            attr_byte = '0;
            shifter = '0;
            ink = '0;
            paper = '0;
            border_rgb = '0;
            flash_bright_bits = '0;
            border_area = 1'b0;
            parity_bit = 1'b0;
            ras_st = 1'b0;
            cas_st = 1'b0;
            cpu_clk_st = 1'b0;
            mreq_seen = 1'b0;
            iorq_seen = 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                chip_sel = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                if (i_in_item.operation == rvcg_pkg::OP_BORDER_WRITE) begin
                    border_rgb = i_in_item.data_byte[2:0];
                    border_writes++;
                end else begin
                    due_pixels.push_back(advance_raster(i_in_item));
                    ticks_seen++;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                if (due_pixels.size() == 0) begin
                    log_mismatch("result item arrived with nothing expected");
                end else begin
                    want = due_pixels.pop_front();
                    compare_field("pixel_code", int'(o_out_item.pixel_code),
                                  int'(want.pixel_code));
                    compare_field("hsync", int'(o_out_item.hsync), int'(want.hsync));
                    compare_field("vsync", int'(o_out_item.vsync), int'(want.vsync));
                    compare_field("hblank", int'(o_out_item.hblank), int'(want.hblank));
                    compare_field("colour_burst", int'(o_out_item.colour_burst),
                                  int'(want.colour_burst));
                    compare_field("odd_line", int'(o_out_item.odd_line),
                                  int'(want.odd_line));
                    compare_field("video_address", int'(o_out_item.video_address),
                                  int'(want.video_address));
                    compare_field("address_valid", int'(o_out_item.address_valid),
                                  int'(want.address_valid));
                    compare_field("video_ras", int'(o_out_item.video_ras),
                                  int'(want.video_ras));
                    compare_field("video_cas", int'(o_out_item.video_cas),
                                  int'(want.video_cas));
                    compare_field("frame_interrupt", int'(o_out_item.frame_interrupt),
                                  int'(want.frame_interrupt));
                    compare_field("cpu_clock", int'(o_out_item.cpu_clock),
                                  int'(want.cpu_clock));
                end
            end
        end
    end

    // While idle_on is set, the video side stalls at random with a probability of seven percent.
    always @(posedge i_clk) begin
        i_out_stall <= idle_on && ($urandom_range(99, 0) < 7);
    end

    // A hung handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding",
                     cycle_count, due_pixels.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Offers one item and returns at the edge that accepts it. A gap, when
    // one is drawn, comes before valid is raised, so valid is never lowered
    // and raised in the same step.
    task automatic send_item(input rvcg_pkg::t_in_item it);
        if (idle_on && $urandom_range(99, 0) < 7) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Holds off the input until every owed result has come back, then lets
    // the block go quiet. The raster state is stable afterwards.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_chip_type(input logic [2:0] kind);
        drain_results();
        i_cfg_valid <= 1'b1;
        i_cfg_data <= kind;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // A bus cycle as the CPU would show it: random address lines and requests,
    // and now and then a port write to the border.
    function automatic rvcg_pkg::t_in_item random_bus_item(input int unsigned border_pct);
        rvcg_pkg::t_in_item it;

        it.operation = ($urandom_range(99, 0) < border_pct) ? rvcg_pkg::OP_BORDER_WRITE
                                                              : rvcg_pkg::OP_TICK;
        it.data_byte = 8'($urandom_range(255, 0));
        it.addr_bit14 = 1'($urandom_range(1, 0));
        it.addr_bit15 = 1'($urandom_range(1, 0));
        it.mem_request_n = 1'($urandom_range(1, 0));
        it.io_request_n = $urandom_range(99, 0) >= 30;
        return it;
    endfunction

    // Sends random items until the given number of ticks has gone out. Border
    // writes come on top of that count.
    task automatic run_ticks(input int unsigned count, input int unsigned border_pct,
                             input bit with_pauses);
        int unsigned done;
        rvcg_pkg::t_in_item it;

        done = 0;
        while (done < count) begin
            it = random_bus_item(border_pct);
            if (it.operation == rvcg_pkg::OP_TICK) begin
                done++;
            end
            send_item(it);
            if (with_pauses && $urandom_range(199, 0) == 0) begin
                drain_results();
            end
        end
    endtask

    // Straight after reset: border writes with the extremes of the data byte,
    // then the first fetch group of line 0 with every mix of address lines
    // and requests.
    task automatic test_reset_and_edges();
        rvcg_pkg::t_in_item it;
        int i;

        it = '0;
        it.operation = rvcg_pkg::OP_BORDER_WRITE;
        it.data_byte = 8'hff;
        send_item(it);
        // Only the low three bits reach the border, so this one selects black.
        it.data_byte = 8'hf8;
        send_item(it);
        for (i = 0; i < 20; i++) begin
            it.operation = rvcg_pkg::OP_TICK;
            case (i % 4)
                0: it.data_byte = 8'h00;
                1: it.data_byte = 8'hff;
                2: it.data_byte = 8'haa;
                default: it.data_byte = 8'h55;
            endcase
            it.addr_bit14 = i[0];
            it.addr_bit15 = i[1];
            it.mem_request_n = i[2];
            it.io_request_n = i[3];
            send_item(it);
            if (i == 9) begin
                it.operation = rvcg_pkg::OP_BORDER_WRITE;
                it.data_byte = 8'h05;
                send_item(it);
            end
        end
        drain_results();
    endtask

    // Random bus traffic over the first display lines under each chip type's
    // contention rules, the undefined codes among them.
    task automatic test_contention_per_type();
        logic [2:0] kinds [8];
        int k;

        kinds = '{rvcg_pkg::CHIP_5C102E, rvcg_pkg::CHIP_5C112E, rvcg_pkg::CHIP_6C001E6,
                  rvcg_pkg::CHIP_6C001E7, rvcg_pkg::CHIP_6C011E, 3'd5, 3'd6, 3'd7};
        for (k = 0; k < 8; k++) begin
            set_chip_type(kinds[k]);
            run_ticks(TICKS_PER_MIX, 6, 1'b1);
        end
    endtask

    // A stretch under the NTSC chip with no gaps or stalls on either side.
    task automatic test_ntsc_no_idle();
        set_chip_type(rvcg_pkg::CHIP_6C011E);
        idle_on = 1'b0;
        run_ticks(NO_IDLE_TICKS, 1, 1'b0);
        drain_results();
        idle_on = 1'b1;
    endtask

    initial begin : main
        int unsigned waited;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_and_edges();
        test_contention_per_type();
        test_ntsc_no_idle();

        // Wait a bounded time for the last results, then let the block settle.
        i_in_valid <= 1'b0;
        for (waited = 0; waited < 2000 && due_pixels.size() != 0; waited++) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_pixels.size() != 0) begin
            log_mismatch($sformatf("%0d expected results never arrived",
                                   due_pixels.size()));
        end

        $display("Checked %0d pixel ticks and %0d border writes under all eight chip codes",
                 ticks_seen, border_writes);
        $display("Random contention traffic per code and a stall-free NTSC run; %0d errors",
                 mismatches);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== raster_video_and_cpu_clock_gen_unit.f =====
hdl/rvcg_pkg.sv
hdl/raster_video_and_cpu_clock_gen_unit.sv
verif/raster_video_and_cpu_clock_gen_unit_test.sv
